// ===== hw/rtl/dls_pkg.sv =====
// shared constants, types and helpers for the dda line stepper
package dls_pkg;

    localparam int COORD_BITS = 10;
    localparam int FRAC_BITS  = 24;

    // accumulator and increment width: integer part plus fraction
    localparam int ACC_W      = COORD_BITS + FRAC_BITS;
    localparam int STEPS_W    = COORD_BITS + 1;
    localparam int K_W        = $clog2(COORD_BITS + 1);
    localparam int DIV_CNT_W  = $clog2(ACC_W);

    // initial fraction bias so the floor at the endpoint is exact
    localparam logic [ACC_W-1:0] FRAC_BIAS = ACC_W'(1) << (FRAC_BITS - 14);

    // request codes
    localparam logic REQ_START = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_X,
        ST_RUN_X,
        ST_LOAD_Y,
        ST_RUN_Y
    } state_t;

    typedef struct packed {
        logic                  req_type;
        logic [COORD_BITS-1:0] start_x;
        logic [COORD_BITS-1:0] start_y;
        logic [COORD_BITS-1:0] end_x;
        logic [COORD_BITS-1:0] end_y;
        logic                  use_symmetric;
    } req_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] point_x;
        logic [COORD_BITS-1:0] point_y;
        logic                  last_point;
    } pnt_t;

    // number of significant bits of a value: log2 of the smallest power of two above it
    function automatic logic [K_W-1:0] bit_length(input logic [COORD_BITS-1:0] v);
        logic [K_W-1:0] len;
        len = '0;
        for (int i = 0; i < COORD_BITS; i++)
        begin
            if (v[i])
            begin
                len = K_W'(i + 1);
            end
        end
        return len;
    endfunction

endpackage

// ===== hw/rtl/dls_divider.sv =====
// restoring divider, one quotient bit per cycle: (dividend << FRAC_BITS) / divisor
module dls_divider
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic [dls_pkg::COORD_BITS-1:0] dividend,
    input  logic [dls_pkg::COORD_BITS-1:0] divisor,
    output logic                           done,
    output logic [dls_pkg::ACC_W-1:0]      quotient
);

    logic                             busy_reg;
    logic                             done_reg;
    logic [dls_pkg::DIV_CNT_W-1:0]    cnt_reg;
    logic [dls_pkg::COORD_BITS-1:0]   rem_reg;
    logic [dls_pkg::COORD_BITS-1:0]   dvs_reg;
    logic [dls_pkg::ACC_W-1:0]        dq_reg;

    logic [dls_pkg::COORD_BITS:0]     shifted;
    logic [dls_pkg::COORD_BITS:0]     diff;
    logic                             ge;
    logic                             last_iter;

    // one restoring step: shift in next dividend bit, trial subtract
    always_comb
    begin
        shifted   = {rem_reg, dq_reg[dls_pkg::ACC_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        ge        = (shifted >= {1'b0, dvs_reg});
        last_iter = (cnt_reg == dls_pkg::DIV_CNT_W'(dls_pkg::ACC_W - 1));
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= busy_reg && last_iter;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (last_iter)
                begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    // remainder and dividend/quotient shift register
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvs_reg <= divisor;
            dq_reg  <= {dividend, {dls_pkg::FRAC_BITS{1'b0}}};
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? diff[dls_pkg::COORD_BITS-1:0] : shifted[dls_pkg::COORD_BITS-1:0];
            dq_reg  <= {dq_reg[dls_pkg::ACC_W-2:0], ge};
        end
    end

    assign done     = done_reg;
    assign quotient = dq_reg;

endmodule

// ===== hw/rtl/dda_line_stepper.sv =====
// dda line stepper top level: sequencer, accumulators and point output register
// A start transaction loads two endpoints and a mode and gives no point; a point
// transaction then gives one point of the line, the last one flagged, and a point
// transaction with no line in progress gives nothing. A point transaction is taken
// every cycle while the output register drains. A start in symmetric mode, or with
// equal endpoints, needs no divide. A start in simple mode runs the shared restoring
// divider twice, once per axis, at one quotient bit per cycle, so the block stalls
// requests through the load and run states of both divides.
module dda_line_stepper
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  dls_pkg::req_t req_data,
    output logic          pnt_valid,
    input  logic          pnt_stall,
    output dls_pkg::pnt_t pnt_data
);

    dls_pkg::state_t                 state_reg;
    dls_pkg::state_t                 state_next;

    logic [dls_pkg::ACC_W-1:0]       x_acc_reg;
    logic [dls_pkg::ACC_W-1:0]       y_acc_reg;
    logic [dls_pkg::ACC_W-1:0]       x_step_reg;
    logic [dls_pkg::ACC_W-1:0]       y_step_reg;
    logic [dls_pkg::STEPS_W-1:0]     steps_left_reg;
    logic                            line_active_reg;
    logic [dls_pkg::COORD_BITS-1:0]  dxm_reg;
    logic [dls_pkg::COORD_BITS-1:0]  dym_reg;
    logic [dls_pkg::COORD_BITS-1:0]  len_reg;
    logic                            xneg_reg;
    logic                            yneg_reg;
    logic                            pnt_valid_reg;
    dls_pkg::pnt_t                   pnt_data_reg;

    logic                            accept;
    logic                            start_acc;
    logic                            point_acc;
    logic                            pnt_load;
    logic                            is_last;
    logic                            xneg;
    logic                            yneg;
    logic [dls_pkg::COORD_BITS-1:0]  dxm;
    logic [dls_pkg::COORD_BITS-1:0]  dym;
    logic [dls_pkg::COORD_BITS-1:0]  len;
    logic [dls_pkg::K_W-1:0]         k;
    logic                            use_div;

    logic                            div_start;
    logic [dls_pkg::COORD_BITS-1:0]  div_dividend;
    logic                            div_done;
    logic [dls_pkg::ACC_W-1:0]       div_q;

    // handshake decode
    always_comb
    begin
        accept    = req_valid && !req_stall;
        start_acc = accept && (req_data.req_type == dls_pkg::REQ_START);
        point_acc = accept && (req_data.req_type == dls_pkg::REQ_POINT);
        pnt_load  = point_acc && line_active_reg;
        is_last   = (steps_left_reg == '0);
    end

    // endpoint differences, major length and power-of-two exponent
    always_comb
    begin
        xneg    = (req_data.end_x < req_data.start_x);
        yneg    = (req_data.end_y < req_data.start_y);
        dxm     = xneg ? (req_data.start_x - req_data.end_x) : (req_data.end_x - req_data.start_x);
        dym     = yneg ? (req_data.start_y - req_data.end_y) : (req_data.end_y - req_data.start_y);
        len     = (dxm > dym) ? dxm : dym;
        k       = dls_pkg::bit_length(len);
        use_div = !req_data.use_symmetric && (len != '0);
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            dls_pkg::ST_IDLE:
            begin
                if (start_acc && use_div)
                begin
                    state_next = dls_pkg::ST_LOAD_X;
                end
            end
            dls_pkg::ST_LOAD_X:
            begin
                state_next = dls_pkg::ST_RUN_X;
            end
            dls_pkg::ST_RUN_X:
            begin
                if (div_done)
                begin
                    state_next = dls_pkg::ST_LOAD_Y;
                end
            end
            dls_pkg::ST_LOAD_Y:
            begin
                state_next = dls_pkg::ST_RUN_Y;
            end
            dls_pkg::ST_RUN_Y:
            begin
                if (div_done)
                begin
                    state_next = dls_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = dls_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = dym_reg;
        req_stall    = 1'b1;
        case (state_reg)
            dls_pkg::ST_IDLE:
            begin
                req_stall = pnt_valid_reg && pnt_stall;
            end
            dls_pkg::ST_LOAD_X:
            begin
                div_start    = 1'b1;
                div_dividend = dxm_reg;
            end
            dls_pkg::ST_LOAD_Y:
            begin
                div_start = 1'b1;
            end
            default:
            begin
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dls_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // shared divider for both axes
    dls_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (len_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // line state: accumulators, increments, step count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_acc_reg       <= '0;
            y_acc_reg       <= '0;
            x_step_reg      <= '0;
            y_step_reg      <= '0;
            steps_left_reg  <= '0;
            line_active_reg <= 1'b0;
        end
        else if (start_acc)
        begin
            x_acc_reg       <= {req_data.start_x, {dls_pkg::FRAC_BITS{1'b0}}} + dls_pkg::FRAC_BIAS;
            y_acc_reg       <= {req_data.start_y, {dls_pkg::FRAC_BITS{1'b0}}} + dls_pkg::FRAC_BIAS;
            line_active_reg <= 1'b1;
            if (len == '0)
            begin
                x_step_reg     <= '0;
                y_step_reg     <= '0;
                steps_left_reg <= '0;
            end
            else if (req_data.use_symmetric)
            begin
                x_step_reg <= xneg
                    ? (dls_pkg::ACC_W'(0) - ({dxm, {dls_pkg::FRAC_BITS{1'b0}}} >> k))
                    : ({dxm, {dls_pkg::FRAC_BITS{1'b0}}} >> k);
                y_step_reg <= yneg
                    ? (dls_pkg::ACC_W'(0) - ({dym, {dls_pkg::FRAC_BITS{1'b0}}} >> k))
                    : ({dym, {dls_pkg::FRAC_BITS{1'b0}}} >> k);
                steps_left_reg <= dls_pkg::STEPS_W'(1) << k;
            end
            else
            begin
                steps_left_reg <= {1'b0, len};
            end
        end
        else if (div_done && (state_reg == dls_pkg::ST_RUN_X))
        begin
            x_step_reg <= xneg_reg ? (dls_pkg::ACC_W'(0) - div_q) : div_q;
        end
        else if (div_done && (state_reg == dls_pkg::ST_RUN_Y))
        begin
            y_step_reg <= yneg_reg ? (dls_pkg::ACC_W'(0) - div_q) : div_q;
        end
        else if (pnt_load)
        begin
            if (is_last)
            begin
                line_active_reg <= 1'b0;
            end
            else
            begin
                x_acc_reg      <= x_acc_reg + x_step_reg;
                y_acc_reg      <= y_acc_reg + y_step_reg;
                steps_left_reg <= steps_left_reg - 1'b1;
            end
        end
    end

    // divider operands captured at start
    always_ff @(posedge clk)
    begin
        if (start_acc)
        begin
            dxm_reg  <= dxm;
            dym_reg  <= dym;
            len_reg  <= len;
            xneg_reg <= xneg;
            yneg_reg <= yneg;
        end
    end

    // point output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pnt_valid_reg <= 1'b0;
        end
        else if (pnt_load)
        begin
            pnt_valid_reg <= 1'b1;
        end
        else if (!pnt_stall)
        begin
            pnt_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pnt_load)
        begin
            pnt_data_reg.point_x    <= x_acc_reg[dls_pkg::ACC_W-1:dls_pkg::FRAC_BITS];
            pnt_data_reg.point_y    <= y_acc_reg[dls_pkg::ACC_W-1:dls_pkg::FRAC_BITS];
            pnt_data_reg.last_point <= is_last;
        end
    end

    assign pnt_valid = pnt_valid_reg;
    assign pnt_data  = pnt_data_reg;

    // no request taken while the divider sequence runs
    a_stall_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != dls_pkg::ST_IDLE) |-> req_stall)
        else $error("request accepted during divide");

    // divider completes only while the sequencer waits for it
    a_done_in_run: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> ((state_reg == dls_pkg::ST_RUN_X) || (state_reg == dls_pkg::ST_RUN_Y)))
        else $error("divider done outside a run state");

    // emitting the last point ends the line
    a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
        (pnt_load && is_last) |=> (!line_active_reg && pnt_valid && pnt_data.last_point))
        else $error("line still active after last point");

    // a point is only produced from an active line
    a_point_needs_line: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(pnt_valid) |-> $past(line_active_reg))
        else $error("point emitted with no active line");

endmodule
